>>> hdl/cgps_pkg.sv
// Shared constants, types and the exponential table of the cylinder pulse source.
`default_nettype none

package cgps_pkg;

  localparam int DIMS            = 3;
  localparam int COORD_BITS      = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_DEPTH_LOG2  = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_ARG_RANGE   = 16;
  localparam int Z_CUTOFF        = 6;

  // Configuration port
  localparam int CFG_W     = 3 * COORD_BITS;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROD_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CTR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd5;

  // Geometry widths
  localparam int DIFF_W  = COORD_BITS + 1;          // p - S, E - S
  localparam int H_W     = 2 * (DIFF_W - 1) + 2;    // |v|^2
  localparam int S_W     = H_W + 1;                 // d.v, signed
  localparam int CROSS_W = 2 * (DIFF_W - 1) + 2;    // one cross product component
  localparam int CMAG_W  = CROSS_W - 1;
  localparam int LHS_W   = 2 * CMAG_W + 2;
  localparam int RAD_W   = COORD_BITS;
  localparam int RR_W    = 2 * RAD_W;
  localparam int RHS_W   = RR_W + H_W;

  // Axis length and unit vector
  localparam int SQN_W   = H_W + 16;
  localparam int LEN_W   = (SQN_W + 1) / 2;
  localparam int UU_SH   = 38;
  localparam int UDIV_N  = DIFF_W - 1 + UU_SH + 1;
  localparam int UU_W    = 31;

  // Pulse widths
  localparam int T_W     = 32;
  localparam int TAU_W   = T_W + 1;
  localparam int W_W     = 31;
  localparam int DIV_N   = TAU_W + 16;
  localparam int Z_W     = $clog2(Z_CUTOFF) + 16;
  localparam int ZSQ_W   = 2 * Z_W;
  localparam int EXP_W   = 17;
  localparam int X_W     = Z_W + EXP_W;
  localparam int P_W     = 64;
  localparam int ARG_SHIFT = $clog2(2 * EXP_ARG_RANGE) + 32 - EXP_DEPTH_LOG2;
  localparam int IDX_W   = ZSQ_W - ARG_SHIFT;
  localparam int MM_LO   = 24;
  localparam int MM_HI   = DIV_N - MM_LO;
  localparam int PL_W    = MM_LO + UU_W;
  localparam int PH_W    = MM_HI + UU_W;
  localparam int PS_W    = PH_W + MM_LO + 1;

  typedef struct packed {
    logic in_rod;
    logic mneg;
  } side_t;

  typedef struct packed {
    logic [CFG_W-1:0]                 start;
    logic [T_W-1:0]                   amp;
    logic [T_W-1:0]                   center;
    logic [W_W-1:0]                   width;
    logic [DIMS-1:0][DIFF_W-1:0]      v;
    logic [H_W-1:0]                   h;
    logic [RHS_W-1:0]                 rhs;
    logic [DIMS-1:0][UU_W-1:0]        uu;
    logic                             busy;
  } cfg_t;

  typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // exp(-k*EXP_ARG_RANGE/DEPTH) in Q1.16: series for exp(-k/DEPTH), then raised to 16.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t          rom;
    longint unsigned   y;
    longint unsigned   term;
    longint unsigned   s;
    longint            sum;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      y    = 64'(k) << (31 - EXP_DEPTH_LOG2);
      term = 64'd1 << 31;
      sum  = longint'(term);
      for (int n = 1; n <= 24; n++) begin
        term = ((term * y) >> 31) / 64'(n);
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 31)) sum = longint'(64'd1 << 31);
      s = longint'(sum);
      for (int q = 0; q < 4; q++) begin
        s = (s * s + (64'd1 << 30)) >> 31;
      end
      rom[k] = EXP_W'((s + (64'd1 << 14)) >> 15);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

>>> hdl/cgps_setup.sv
// Configuration registers and the sequencer that derives axis constants from them.
`default_nettype none

module cgps_setup import cgps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_VEC   = 3'd1;
  localparam logic [2:0] ST_H     = 3'd2;
  localparam logic [2:0] ST_RHS   = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;

  logic [CFG_W-1:0]         start_r, end_r;
  logic [RAD_W-1:0]         radius_r;
  logic [T_W-1:0]           amp_r, center_r;
  logic [W_W-1:0]           width_r;

  logic [2:0]               state_r, state_nxt;
  logic signed [DIFF_W-1:0] v_r [DIMS];
  logic [H_W-1:0]           h_r;
  logic [RR_W-1:0]          rr_r;
  logic [RHS_W-1:0]         rhs_r;
  logic [SQN_W-1:0]         sq_n_r, sq_res_r, sq_bit_r;
  logic [LEN_W-1:0]         len_r;
  logic [UDIV_N-1:0]        dv_num_r;
  logic [LEN_W-1:0]         dv_rem_r;
  logic [5:0]               dv_cnt_r;
  logic [1:0]               comp_r;
  logic [UU_W-1:0]          uu_r [DIMS];

  logic signed [DIFF_W-1:0] v_calc [DIMS];
  logic signed [H_W-1:0]    vsq [DIMS];
  logic [H_W-1:0]           h_calc;
  logic [SQN_W:0]           sq_sum;
  logic                     sq_ge;
  logic [LEN_W:0]           dv_trial, dv_diff;
  logic                     dv_ge;
  logic [DIFF_W-2:0]        vabs;
  logic signed [DIFF_W-1:0] vsel;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      radius_r <= '0;
      amp_r    <= '0;
      center_r <= '0;
      width_r  <= W_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AXIS_START:  start_r  <= cfg_wdata;
        CFG_AXIS_END:    end_r    <= cfg_wdata;
        CFG_ROD_RADIUS:  radius_r <= cfg_wdata[RAD_W-1:0];
        CFG_PULSE_AMP:   amp_r    <= cfg_wdata[T_W-1:0];
        CFG_PULSE_CTR:   center_r <= cfg_wdata[T_W-1:0];
        CFG_PULSE_WIDTH: width_r  <= cfg_wdata[W_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      v_calc[i] = signed'({end_r[i*COORD_BITS+COORD_BITS-1], end_r[i*COORD_BITS +: COORD_BITS]})
                - signed'({start_r[i*COORD_BITS+COORD_BITS-1],
                           start_r[i*COORD_BITS +: COORD_BITS]});
      vsq[i]    = v_r[i] * v_r[i];
    end
    h_calc   = vsq[0] + vsq[1] + vsq[2];
    sq_sum   = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
    sq_ge    = {1'b0, sq_n_r} >= sq_sum;
    vsel     = v_r[comp_r];
    vabs     = vsel[DIFF_W-1] ? (DIFF_W-1)'(-vsel) : vsel[DIFF_W-2:0];
    dv_trial = {dv_rem_r, dv_num_r[UDIV_N-1]};
    dv_ge    = dv_trial >= {1'b0, len_r};
    dv_diff  = dv_trial - {1'b0, len_r};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  state_nxt = ST_IDLE;
      ST_VEC:   state_nxt = ST_H;
      ST_H:     state_nxt = ST_RHS;
      ST_RHS:   state_nxt = ST_SQRT;
      ST_SQRT:  if (sq_bit_r == SQN_W'(1)) state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dv_cnt_r == 6'(UDIV_N - 1)) begin
          state_nxt = (comp_r == 2'(DIMS - 1)) ? ST_IDLE : ST_DINIT;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Restart the derivation on reset and on every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_VEC;
    end else if (cfg_we) begin
      state_r <= ST_VEC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_VEC: begin
        for (int i = 0; i < DIMS; i++) v_r[i] <= v_calc[i];
      end
      ST_H: begin
        h_r  <= h_calc;
        rr_r <= RR_W'(radius_r * radius_r);
      end
      ST_RHS: begin
        rhs_r    <= RHS_W'(rr_r * h_r);
        sq_n_r   <= {h_r, 16'b0};
        sq_res_r <= '0;
        sq_bit_r <= SQN_W'(1) << (SQN_W - 2);
        comp_r   <= '0;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_n_r   <= sq_n_r - sq_sum[SQN_W-1:0];
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ST_DINIT: begin
        len_r    <= sq_res_r[LEN_W-1:0];
        dv_num_r <= {1'b0, vabs, UU_SH'(0)} + UDIV_N'(sq_res_r[LEN_W-1:1]);
        dv_rem_r <= '0;
        dv_cnt_r <= '0;
      end
      ST_DIV: begin
        dv_rem_r <= dv_ge ? dv_diff[LEN_W-1:0] : dv_trial[LEN_W-1:0];
        dv_num_r <= {dv_num_r[UDIV_N-2:0], dv_ge};
        dv_cnt_r <= dv_cnt_r + 6'd1;
        if (dv_cnt_r == 6'(UDIV_N - 1)) begin
          uu_r[comp_r] <= {dv_num_r[UU_W-2:0], dv_ge};
          comp_r       <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg.start  = start_r;
    cfg.amp    = amp_r;
    cfg.center = center_r;
    cfg.width  = width_r;
    for (int i = 0; i < DIMS; i++) begin
      cfg.v[i]  = v_r[i];
      cfg.uu[i] = uu_r[i];
    end
    cfg.h    = h_r;
    cfg.rhs  = rhs_r;
    cfg.busy = state_r != ST_IDLE;
  end

endmodule

`default_nettype wire

>>> hdl/cgps_geom.sv
// Four-stage pipeline for the rod test: offsets, dot and cross products, squares, compare.
`default_nettype none

module cgps_geom import cgps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  input  logic signed [T_W-1:0]   sim_time,
  input  cfg_t                    cfg,
  output logic                    out_valid,
  output logic                    out_inside,
  output logic signed [TAU_W-1:0] out_tau
);

  logic signed [DIFF_W-1:0]  vs [DIMS];
  logic signed [COORD_BITS-1:0] pin [DIMS];
  logic signed [COORD_BITS-1:0] sc [DIMS];

  logic                      vld1_r, vld2_r, vld3_r, vld4_r;
  logic signed [DIFF_W-1:0]  d1_r [DIMS];
  logic signed [TAU_W-1:0]   tau1_r, tau2_r, tau3_r, tau4_r;
  logic signed [S_W-1:0]     s2_r;
  logic signed [CROSS_W-1:0] c2_r [DIMS];
  logic [2*CMAG_W-1:0]       sq3_r [DIMS];
  logic                      sok3_r, in4_r;

  logic signed [DIFF_W-1:0]  d_calc [DIMS];
  logic signed [TAU_W-1:0]   tau_calc;
  logic signed [2*DIFF_W-1:0] dv [DIMS];
  logic signed [2*DIFF_W-1:0] xa [DIMS];
  logic signed [2*DIFF_W-1:0] xb [DIMS];
  logic signed [S_W-1:0]     s_calc;
  logic [CMAG_W-1:0]         cmag [DIMS];
  logic [LHS_W-1:0]          lhs;

  always_comb begin
    pin[0] = px;
    pin[1] = py;
    pin[2] = pz;
    for (int i = 0; i < DIMS; i++) begin
      vs[i]     = signed'(cfg.v[i]);
      sc[i]     = signed'(cfg.start[i*COORD_BITS +: COORD_BITS]);
      d_calc[i] = DIFF_W'(pin[i]) - DIFF_W'(sc[i]);
    end
    tau_calc = TAU_W'(sim_time) - TAU_W'(signed'(cfg.center));

    for (int i = 0; i < DIMS; i++) begin
      dv[i] = d1_r[i] * vs[i];
    end
    xa[0] = d1_r[1] * vs[2];  xb[0] = d1_r[2] * vs[1];
    xa[1] = d1_r[2] * vs[0];  xb[1] = d1_r[0] * vs[2];
    xa[2] = d1_r[0] * vs[1];  xb[2] = d1_r[1] * vs[0];
    s_calc = S_W'(dv[0]) + S_W'(dv[1]) + S_W'(dv[2]);

    for (int i = 0; i < DIMS; i++) begin
      cmag[i] = c2_r[i][CROSS_W-1] ? CMAG_W'(-c2_r[i]) : c2_r[i][CMAG_W-1:0];
    end
    lhs = LHS_W'(sq3_r[0]) + LHS_W'(sq3_r[1]) + LHS_W'(sq3_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIMS; i++) begin
        d1_r[i]  <= d_calc[i];
        c2_r[i]  <= CROSS_W'(xa[i] - xb[i]);
        sq3_r[i] <= cmag[i] * cmag[i];
      end
      tau1_r <= tau_calc;
      tau2_r <= tau1_r;
      tau3_r <= tau2_r;
      tau4_r <= tau3_r;
      s2_r   <= s_calc;
      sok3_r <= !s2_r[S_W-1] && (s2_r <= signed'({1'b0, cfg.h}));
      in4_r  <= (cfg.h != '0) && sok3_r && (lhs <= LHS_W'(cfg.rhs));
    end
  end

  assign out_valid  = vld4_r;
  assign out_inside = in4_r;
  assign out_tau    = tau4_r;

endmodule

`default_nettype wire

>>> hdl/cgps_div.sv
// Pipelined restoring divider by the pulse width, one quotient bit per stage.
`default_nettype none

module cgps_div import cgps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [DIV_N-1:0] in_num,
  input  logic [W_W-1:0]   divisor,
  output logic             out_valid,
  output side_t            out_side,
  output logic [DIV_N-1:0] out_quot
);

  logic             vld_r  [DIV_N];
  side_t            side_r [DIV_N];
  logic [W_W-1:0]   rem_r  [DIV_N];
  logic [DIV_N-1:0] num_r  [DIV_N];

  logic [W_W-1:0]   rem_nxt [DIV_N];
  logic [DIV_N-1:0] num_nxt [DIV_N];
  logic [W_W-1:0]   rem_in  [DIV_N];
  logic [DIV_N-1:0] num_in  [DIV_N];
  logic [W_W:0]     trial   [DIV_N];
  logic [W_W:0]     diff    [DIV_N];
  logic             ge      [DIV_N];

  always_comb begin
    for (int k = 0; k < DIV_N; k++) begin
      rem_in[k]  = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k-1];
      num_in[k]  = (k == 0) ? in_num : num_r[(k == 0) ? 0 : k-1];
      trial[k]   = {rem_in[k], num_in[k][DIV_N-1]};
      diff[k]    = trial[k] - {1'b0, divisor};
      ge[k]      = trial[k] >= {1'b0, divisor};
      rem_nxt[k] = ge[k] ? diff[k][W_W-1:0] : trial[k][W_W-1:0];
      num_nxt[k] = {num_in[k][DIV_N-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < DIV_N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_N; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < DIV_N; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[DIV_N-1];
  assign out_side  = side_r[DIV_N-1];
  assign out_quot  = num_r[DIV_N-1];

endmodule

`default_nettype wire

>>> hdl/cylinder_gaussian_pulse_source.sv
// Top level of the cylinder current source with a Gaussian-derivative pulse.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid/in_ready   | in_px, in_py, in_pz (Q4.12), in_sim_time
//  out     | out_valid/out_ready | out_jx, out_jy, out_jz (Q16.16), out_inside_rod
//  cfg     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One transfer per cycle unless stalled (out_ready, cfg.busy); 4 geometry stages,
// two 49-stage width dividers, 5 pulse stages, 2 scaling stages and the output register.
// After reset and after every cfg write the setup sequencer derives the axis
// vector, r^2*|v|^2, |v| (square root, 25 steps) and the unit vector (3 divisions):
// in_ready stays low until the derivation is done.
// All stages advance together whenever the output register is empty or taken;
// a stall holds every stage, so nothing is dropped or repeated.
`default_nettype none

module cylinder_gaussian_pulse_source import cgps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  input  logic signed [T_W-1:0]        in_sim_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [T_W-1:0]        out_jx,
  output logic signed [T_W-1:0]        out_jy,
  output logic signed [T_W-1:0]        out_jz,
  output logic                         out_inside_rod
);

  localparam logic [DIV_N-1:0] ZCUT    = DIV_N'(Z_CUTOFF) << 16;
  localparam logic [PS_W-30:0] SAT_POS = (PS_W-29)'(32'h7FFF_FFFF);
  localparam logic [PS_W-30:0] SAT_NEG = (PS_W-29)'(32'h8000_0000);

  cfg_t cfg;

  logic en, in_take;

  logic                    geo_valid, geo_inside;
  logic signed [TAU_W-1:0] geo_tau;
  logic [TAU_W-1:0]        tau_mag;
  side_t                   d1_side;

  logic                    q1_valid, q2_valid;
  side_t                   q1_side, q2_side;
  logic [DIV_N-1:0]        q1_quot, q2_quot;

  // pulse stages
  logic                    za_vld_r, zb_vld_r, zc_vld_r, zd_vld_r, ze_vld_r;
  side_t                   za_side_r, zb_side_r, zc_side_r, zd_side_r, ze_side_r;
  logic                    za_cut_r;
  logic [Z_W-1:0]          za_z_r, zb_z_r;
  logic [ZSQ_W-1:0]        za_zsq_r;
  logic [EXP_W-1:0]        zb_e_r;
  logic [T_W-1:0]          zc_x_r;
  logic [P_W-1:0]          zd_p_r;
  logic [DIV_N-1:0]        ze_num_r;

  // scaling stages
  logic                    ma_vld_r, mb_vld_r;
  side_t                   ma_side_r, mb_side_r;
  logic [PL_W-1:0]         ma_pl_r [DIMS];
  logic [PH_W-1:0]         ma_ph_r [DIMS];
  logic [PS_W-1:0]         mb_p_r  [DIMS];

  logic                    out_valid_r, out_inside_r;
  logic [T_W-1:0]          out_j_r [DIMS];

  logic [IDX_W-1:0]        idx;
  logic [EXP_W-1:0]        e_calc;
  logic [X_W-1:0]          x_full;
  logic [T_W-1:0]          amp_mag;
  logic [P_W:0]            num2_sum;
  logic [PS_W-30:0]        rnd [DIMS];
  logic [PS_W-30:0]        lim [DIMS];
  logic [T_W-1:0]          sat [DIMS];
  logic                    neg [DIMS];
  logic [T_W-1:0]          j_nxt [DIMS];

  // Advance the whole pipeline when the output register is free
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && !cfg.busy;
  assign in_take  = in_valid && in_ready;

  cgps_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cgps_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_take),
    .px         (in_px),
    .py         (in_py),
    .pz         (in_pz),
    .sim_time   (in_sim_time),
    .cfg        (cfg),
    .out_valid  (geo_valid),
    .out_inside (geo_inside),
    .out_tau    (geo_tau)
  );

  // z = |tau| * 2^16 / w
  always_comb begin
    tau_mag        = geo_tau[TAU_W-1] ? TAU_W'(-geo_tau) : geo_tau;
    d1_side.in_rod = geo_inside;
    d1_side.mneg   = geo_tau[TAU_W-1] ^ cfg.amp[T_W-1];
  end

  cgps_div u_div_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (geo_valid),
    .in_side   (d1_side),
    .in_num    ({tau_mag, 16'b0}),
    .divisor   (cfg.width),
    .out_valid (q1_valid),
    .out_side  (q1_side),
    .out_quot  (q1_quot)
  );

  always_comb begin
    idx      = za_zsq_r[ZSQ_W-1:ARG_SHIFT];
    // Large argument: past the cutoff or beyond the table the exponential is zero
    e_calc   = (!za_cut_r && !idx[IDX_W-1]) ? EXP_ROM[idx[EXP_DEPTH_LOG2-1:0]] : '0;
    x_full   = zb_z_r * zb_e_r;
    amp_mag  = cfg.amp[T_W-1] ? T_W'(-cfg.amp) : cfg.amp;
    // round half up: (P + den/2) / den with den = w * 2^16
    num2_sum = {1'b0, zd_p_r} + (P_W+1)'({cfg.width, 15'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      za_vld_r <= 1'b0;
      zb_vld_r <= 1'b0;
      zc_vld_r <= 1'b0;
      zd_vld_r <= 1'b0;
      ze_vld_r <= 1'b0;
    end else if (en) begin
      za_vld_r <= q1_valid;
      zb_vld_r <= za_vld_r;
      zc_vld_r <= zb_vld_r;
      zd_vld_r <= zc_vld_r;
      ze_vld_r <= zd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_side_r <= q1_side;
      za_cut_r  <= q1_quot >= ZCUT;
      za_z_r    <= q1_quot[Z_W-1:0];
      za_zsq_r  <= q1_quot[Z_W-1:0] * q1_quot[Z_W-1:0];

      zb_side_r <= za_side_r;
      zb_z_r    <= za_z_r;
      zb_e_r    <= e_calc;

      zc_side_r <= zb_side_r;
      zc_x_r    <= (x_full[X_W-1:T_W] != '0) ? '1 : x_full[T_W-1:0];

      zd_side_r <= zc_side_r;
      zd_p_r    <= amp_mag * zc_x_r;

      ze_side_r <= zd_side_r;
      ze_num_r  <= num2_sum[DIV_N+15:16];
    end
  end

  // magnitude of the pulse: |amp| * z * e / w
  cgps_div u_div_m (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ze_vld_r),
    .in_side   (ze_side_r),
    .in_num    (ze_num_r),
    .divisor   (cfg.width),
    .out_valid (q2_valid),
    .out_side  (q2_side),
    .out_quot  (q2_quot)
  );

  // Scale by the unit vector: two partial products, then sum, then round and saturate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_vld_r    <= 1'b0;
      mb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ma_vld_r    <= q2_valid;
      mb_vld_r    <= ma_vld_r;
      out_valid_r <= mb_vld_r;
    end
  end

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      rnd[i] = {1'b0, mb_p_r[i][PS_W-1:30]} + (PS_W-29)'(mb_p_r[i][29]);
      neg[i] = mb_side_r.mneg ^ cfg.v[i][DIFF_W-1];
      lim[i] = neg[i] ? SAT_NEG : SAT_POS;
      sat[i] = (rnd[i] > lim[i]) ? lim[i][T_W-1:0] : rnd[i][T_W-1:0];
      // Outside the rod or zero width: drop the vector
      if (!mb_side_r.in_rod || (cfg.width == '0)) begin
        j_nxt[i] = '0;
      end else begin
        j_nxt[i] = neg[i] ? T_W'(-sat[i]) : sat[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_side_r <= q2_side;
      mb_side_r <= ma_side_r;
      for (int i = 0; i < DIMS; i++) begin
        ma_pl_r[i] <= q2_quot[MM_LO-1:0] * cfg.uu[i];
        ma_ph_r[i] <= q2_quot[DIV_N-1:MM_LO] * cfg.uu[i];
        mb_p_r[i]  <= {1'b0, ma_ph_r[i], MM_LO'(0)} + PS_W'(ma_pl_r[i]);
        out_j_r[i] <= j_nxt[i];
      end
      out_inside_r <= mb_side_r.in_rod;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_jx         = out_j_r[0];
  assign out_jy         = out_j_r[1];
  assign out_jz         = out_j_r[2];
  assign out_inside_rod = out_inside_r;

endmodule

`default_nettype wire
